[rtl/abpp_pkg.sv]
// Shared types, constants and arithmetic helpers for the alpha blend pixel packer.
package abpp_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 32;
  localparam int POS_W      = 5;
  localparam int WID_W      = 4;
  localparam int PROD_W     = 16;
  localparam int RECIP_W    = 18;
  localparam int RECIP_SH   = 17;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 5;
  localparam int NUM_CH     = 3;
  localparam int NUM_STG    = 6;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [WID_W-1:0] width;
  } chan_cfg_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RED_POS   = 3'd0,
    REG_RED_WID   = 3'd1,
    REG_GREEN_POS = 3'd2,
    REG_GREEN_WID = 3'd3,
    REG_BLUE_POS  = 3'd4,
    REG_BLUE_WID  = 3'd5
  } cfg_reg_t;

  localparam logic [WID_W-1:0] MAX_WID = 4'd8;
  localparam logic [POS_W-1:0] RED_POS_RST   = 5'd16;
  localparam logic [POS_W-1:0] GREEN_POS_RST = 5'd8;
  localparam logic [POS_W-1:0] BLUE_POS_RST  = 5'd0;
  localparam logic [WID_W-1:0] WID_RST       = 4'd8;

  // full-scale code of a channel, 0 for a zero-width channel
  function automatic logic [CH_W-1:0] max_code(input logic [WID_W-1:0] w);
    logic [WID_W-1:0] n;
    logic [CH_W:0]    m;
    n = (w > MAX_WID) ? MAX_WID : w;
    m = (9'd1 << n) - 9'd1;
    return m[CH_W-1:0];
  endfunction

  // floor(2^17 / maxv) for the supported full-scale codes
  function automatic logic [RECIP_W-1:0] recip(input logic [CH_W-1:0] maxv);
    logic [RECIP_W-1:0] r;
    unique case (maxv)
      8'd1:    r = 18'd131072;
      8'd3:    r = 18'd43690;
      8'd7:    r = 18'd18724;
      8'd15:   r = 18'd8738;
      8'd31:   r = 18'd4228;
      8'd63:   r = 18'd2080;
      8'd127:  r = 18'd1032;
      8'd255:  r = 18'd514;
      default: r = '0;
    endcase
    return r;
  endfunction

  // exact x / 255 for x below 65280
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {9'd0, x[PROD_W-1:CH_W]} + 17'd1;
    return t[PROD_W-1:CH_W];
  endfunction

endpackage

[rtl/abpp_cfg.sv]
// Channel layout register file written through the configuration port.
module abpp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [abpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [abpp_pkg::CFG_DATA_W-1:0] cfg_data,
  output abpp_pkg::chan_cfg_t             red_cfg,
  output abpp_pkg::chan_cfg_t             green_cfg,
  output abpp_pkg::chan_cfg_t             blue_cfg
);
  import abpp_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_cfg   <= '{pos: RED_POS_RST,   width: WID_RST};
      green_cfg <= '{pos: GREEN_POS_RST, width: WID_RST};
      blue_cfg  <= '{pos: BLUE_POS_RST,  width: WID_RST};
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_RED_POS:   red_cfg.pos     <= cfg_data;
        REG_RED_WID:   red_cfg.width   <= cfg_data[WID_W-1:0];
        REG_GREEN_POS: green_cfg.pos   <= cfg_data;
        REG_GREEN_WID: green_cfg.width <= cfg_data[WID_W-1:0];
        REG_BLUE_POS:  blue_cfg.pos    <= cfg_data;
        REG_BLUE_WID:  blue_cfg.width  <= cfg_data[WID_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/abpp_chan.sv]
// One color channel: unpack and widen, blend, scale for repack (stages 1 to 5).
module abpp_chan (
  input  logic                          clk,
  input  logic [abpp_pkg::NUM_STG-1:1]  en,
  input  abpp_pkg::chan_cfg_t           cfg,
  input  logic [abpp_pkg::CH_W-1:0]     src_ch,
  input  logic [abpp_pkg::CH_W-1:0]     alpha,
  input  logic [abpp_pkg::PIX_W-1:0]    dst,
  output logic [abpp_pkg::PROD_W-1:0]   scaled
);
  import abpp_pkg::*;

  logic [CH_W-1:0]   maxv;
  logic [PIX_W-1:0]  dst_sh;
  logic [CH_W-1:0]   raw;
  logic [PROD_W-1:0] x_c;
  logic [PROD_W+RECIP_W-1:0] prod;
  logic [PROD_W-1:0] qm;
  logic [PROD_W-1:0] rem;
  logic [CH_W-1:0]   d_c;
  logic [PROD_W-1:0] num_c;
  logic [CH_W-1:0]   v_c;

  logic [CH_W-1:0]   s1_src, s2_src, s3_src;
  logic [CH_W-1:0]   s1_alpha, s2_alpha, s3_alpha;
  logic [PROD_W-1:0] s1_x, s2_x;
  logic [CH_W-1:0]   s2_q;
  logic [CH_W-1:0]   s3_d;
  logic [PROD_W-1:0] s4_num;

  assign maxv   = max_code(cfg.width);
  assign dst_sh = dst >> cfg.pos;
  assign raw    = dst_sh[CH_W-1:0] & maxv;
  assign x_c    = {raw, 8'h00} - {8'h00, raw};

  // reciprocal estimate is exact or one low
  assign prod = {{RECIP_W{1'b0}}, s1_x} * {{PROD_W{1'b0}}, recip(maxv)};

  assign qm  = {8'h00, s2_q} * {8'h00, maxv};
  assign rem = s2_x - qm;
  assign d_c = (maxv == '0) ? '0 :
               (rem >= {8'h00, maxv}) ? s2_q + 8'd1 : s2_q;

  assign num_c = {8'h00, s3_src} * {8'h00, s3_alpha}
               + {8'h00, s3_d} * {8'h00, 8'hFF - s3_alpha};

  assign v_c = div255(s4_num);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_src   <= src_ch;
      s1_alpha <= alpha;
      s1_x     <= x_c;
    end
    if (en[2]) begin
      s2_src   <= s1_src;
      s2_alpha <= s1_alpha;
      s2_x     <= s1_x;
      s2_q     <= prod[RECIP_SH+CH_W-1:RECIP_SH];
    end
    if (en[3]) begin
      s3_src   <= s2_src;
      s3_alpha <= s2_alpha;
      s3_d     <= d_c;
    end
    if (en[4]) begin
      s4_num <= num_c;
    end
    if (en[5]) begin
      scaled <= {8'h00, v_c} * {8'h00, maxv} + 16'd127;
    end
  end

endmodule

[rtl/alpha_blend_pixel_packer_top.sv]
// Accepted inputs pass the stage registers in order to out_valid; output stalls hold them.
// Throughput: one item per cycle; each stage holds when the stage after it is full and stalled.
// Stages: unpack, reciprocal multiply, widen correction, blend, rescale, pack.
// Reset clears all stage valid bits and loads the default 8:8:8 layout at bits 16/8/0.
// Top level of the alpha blend pixel packer.
module alpha_blend_pixel_packer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [abpp_pkg::PIX_W-1:0]      source_argb,
  input  logic [abpp_pkg::PIX_W-1:0]      dest_packed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [abpp_pkg::PIX_W-1:0]      result_packed,
  output logic                            write_enable,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [abpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [abpp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import abpp_pkg::*;

  chan_cfg_t red_cfg, green_cfg, blue_cfg;

  logic [NUM_STG:1]  vld;
  logic [NUM_STG:1]  rdy;
  logic [PIX_W-1:0]  dst_pipe [1:NUM_STG-1];
  logic              zero_pipe [1:NUM_STG-1];
  logic [PROD_W-1:0] r_scaled, g_scaled, b_scaled;
  logic [PIX_W-1:0]  r_part, g_part, b_part;

  abpp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .red_cfg   (red_cfg),
    .green_cfg (green_cfg),
    .blue_cfg  (blue_cfg)
  );

  always_comb begin
    rdy[NUM_STG] = !vld[NUM_STG] || out_ready;
    for (int k = NUM_STG - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = vld[NUM_STG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NUM_STG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dst_pipe[1]  <= dest_packed;
      zero_pipe[1] <= (source_argb[31:24] == 8'h00);
    end
    for (int k = 2; k <= NUM_STG - 1; k++) begin
      if (rdy[k]) begin
        dst_pipe[k]  <= dst_pipe[k-1];
        zero_pipe[k] <= zero_pipe[k-1];
      end
    end
  end

  abpp_chan u_red (
    .clk    (clk),
    .en     (rdy[NUM_STG-1:1]),
    .cfg    (red_cfg),
    .src_ch (source_argb[23:16]),
    .alpha  (source_argb[31:24]),
    .dst    (dest_packed),
    .scaled (r_scaled)
  );

  abpp_chan u_green (
    .clk    (clk),
    .en     (rdy[NUM_STG-1:1]),
    .cfg    (green_cfg),
    .src_ch (source_argb[15:8]),
    .alpha  (source_argb[31:24]),
    .dst    (dest_packed),
    .scaled (g_scaled)
  );

  abpp_chan u_blue (
    .clk    (clk),
    .en     (rdy[NUM_STG-1:1]),
    .cfg    (blue_cfg),
    .src_ch (source_argb[7:0]),
    .alpha  (source_argb[31:24]),
    .dst    (dest_packed),
    .scaled (b_scaled)
  );

  // bits shifted past the top of the pixel drop out
  assign r_part = {24'h000000, div255(r_scaled)} << red_cfg.pos;
  assign g_part = {24'h000000, div255(g_scaled)} << green_cfg.pos;
  assign b_part = {24'h000000, div255(b_scaled)} << blue_cfg.pos;

  always_ff @(posedge clk) begin
    if (rdy[NUM_STG]) begin
      result_packed <= zero_pipe[NUM_STG-1] ? dst_pipe[NUM_STG-1]
                                            : (r_part | g_part | b_part);
      write_enable  <= !zero_pipe[NUM_STG-1];
    end
  end

endmodule

[dv/alpha_blend_pixel_packer_checker.sv]
// Checker for the alpha blend pixel packer: tracks the layout, predicts each blended pixel, compares.
`timescale 1ns / 100ps

module alpha_blend_pixel_packer_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [abpp_pkg::PIX_W-1:0]      source_argb,
  input  logic [abpp_pkg::PIX_W-1:0]      dest_packed,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [abpp_pkg::PIX_W-1:0]      result_packed,
  input  logic                            write_enable,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [abpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [abpp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              checked
);
  import abpp_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             we;
  } blend_result_t;

  chan_cfg_t     layout [NUM_CH];
  blend_result_t blended_q [$];
  int            n_bad = 0;
  int            n_checked = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic blend_result_t predict_blend(logic [PIX_W-1:0] src,
                                                  logic [PIX_W-1:0] dst);
    blend_result_t r;
    int unsigned   alpha, s, d, v, n, full;
    logic [63:0]   field;
    alpha   = 32'(src[31:24]);
    r.pixel = '0;
    r.we    = 1'b1;
    if (alpha == 0) begin
      r.pixel = dst;
      r.we    = 1'b0;
      return r;
    end
    for (int i = 0; i < NUM_CH; i++) begin
      n = 32'((layout[i].width > MAX_WID) ? MAX_WID : layout[i].width);
      if (n == 0) continue;
      full = (1 << n) - 1;
      s    = 32'(src[23 - 8*i -: 8]);
      if (alpha == 255) begin
        v = s;
      end else begin
        d = (((dst >> layout[i].pos) & full) * 255) / full;
        v = (s * alpha + d * (255 - alpha)) / 255;
      end
      // bits pushed past bit 31 drop out; overlapping fields OR together
      field   = 64'((v * full + 127) / 255) << layout[i].pos;
      r.pixel = r.pixel | field[PIX_W-1:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t: %s mismatch on result %0d: expected %h, got %h",
               $realtime, what, n_checked, want, got);
  endtask

  always @(posedge clk) begin
    blend_result_t want;
    if (rst) begin
      layout[0] = '{pos: RED_POS_RST,   width: WID_RST};
      layout[1] = '{pos: GREEN_POS_RST, width: WID_RST};
      layout[2] = '{pos: BLUE_POS_RST,  width: WID_RST};
      blended_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_RED_POS:   layout[0].pos   = cfg_data;
          REG_RED_WID:   layout[0].width = cfg_data[WID_W-1:0];
          REG_GREEN_POS: layout[1].pos   = cfg_data;
          REG_GREEN_WID: layout[1].width = cfg_data[WID_W-1:0];
          REG_BLUE_POS:  layout[2].pos   = cfg_data;
          REG_BLUE_WID:  layout[2].width = cfg_data[WID_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (blended_q.size() == 0) begin
          report("unexpected result", '0, result_packed);
        end else begin
          want = blended_q.pop_front();
          if (result_packed !== want.pixel) report("result_packed", want.pixel, result_packed);
          if (write_enable !== want.we)
            report("write_enable", PIX_W'(want.we), PIX_W'(write_enable));
          n_checked++;
        end
      end
      if (in_valid && in_ready) blended_q.push_back(predict_blend(source_argb, dest_packed));
    end
    mismatches <= n_bad;
    pending    <= blended_q.size();
    checked    <= n_checked;
  end

endmodule

[dv/alpha_blend_pixel_packer_top_test.sv]
// Testbench top for the alpha blend pixel packer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module alpha_blend_pixel_packer_top_test;
  import abpp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      source_argb = '0;
  logic [PIX_W-1:0]      dest_packed = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      result_packed;
  logic                  write_enable;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches, pending, checked;
  int idle_cycles = 0;
  int n_sent = 0, n_clear = 0, n_opaque = 0, n_mixed = 0, n_layouts = 1;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alpha_blend_pixel_packer_top dut (.*);

  alpha_blend_pixel_packer_checker u_checker (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall before each item while out_stalls_on is set
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
    int gap;
    in_valid    <= 1'b1;
    source_argb <= src;
    dest_packed <= dst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    if (src[31:24] == 8'h00) n_clear++;
    else if (src[31:24] == 8'hFF) n_opaque++;
    else n_mixed++;
    gap = in_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_pixel();
    logic [PIX_W-1:0] src, dst;
    int pick;
    src  = $urandom;
    dst  = $urandom;
    pick = $urandom_range(0, 7);
    if (pick < 2) src[31:24] = 8'h00;
    else if (pick < 4) src[31:24] = 8'hFF;
    else if (pick == 4) src[31:24] = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
    else src[31:24] = 8'($urandom_range(1, 254));
    if ($urandom_range(0, 7) == 0) dst = $urandom_range(0, 1) ? '1 : '0;
    send_pixel(src, dst);
  endtask

  // wait until every expected item is back, then let the pipe go quiet
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NUM_STG + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_layout(input logic [CFG_DATA_W-1:0] rp, rw, gp, gw, bp, bw);
    write_reg(REG_RED_POS, rp);
    write_reg(REG_RED_WID, rw);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_GREEN_POS, gp);
    write_reg(REG_GREEN_WID, gw);
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    write_reg(REG_BLUE_POS, bp);
    write_reg(REG_BLUE_WID, bw);
    cfg_valid <= 1'b0;
    n_layouts++;
  endtask

  initial begin
    int mode;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default 8:8:8 layout
    send_pixel(32'h00FFFFFF, 32'hFFFFFFFF);
    send_pixel(32'h00000000, 32'h00000000);
    send_pixel(32'hFFFFFFFF, 32'h00000000);
    send_pixel(32'hFF000000, 32'hFFFFFFFF);
    send_pixel(32'hFF123456, 32'hA5A5A5A5);
    send_pixel(32'h01FFFFFF, 32'h00000000);
    send_pixel(32'h01000000, 32'hFFFFFFFF);
    send_pixel(32'hFE000000, 32'hFFFFFFFF);
    send_pixel(32'hFEFFFFFF, 32'h00000000);
    send_pixel(32'h80FF00FF, 32'h0000FF00);
    send_pixel(32'h7F00FF00, 32'hFFFF00FF);
    send_pixel(32'h80808080, 32'h80808080);
    repeat (200) send_random_pixel();

    for (int phase = 1; phase < 10; phase++) begin
      settle_pipeline();
      case (phase)
        1: set_layout(5'd11, 5'd5, 5'd5, 5'd6, 5'd0, 5'd5);     // 565
        2: set_layout(5'd31, 5'd8, 5'd0, 5'd0, 5'd28, 5'd12);   // top-bit spill, zero width, wide clamp
        3: set_layout(5'd0, 5'd1, 5'd1, 5'd1, 5'd2, 5'd1);      // one bit per channel
        4: set_layout(5'd4, 5'd8, 5'd4, 5'd31, 5'd4, 5'd15);    // fully overlapping
        5: set_layout(5'd16, 5'd8, 5'd8, 5'd8, 5'd0, 5'd8);
        default: set_layout(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      endcase
      mode          = phase % 4;
      in_gaps_on    = (mode == 0 || mode == 2);
      out_stalls_on = (mode == 0 || mode == 1);
      repeat (200) send_random_pixel();
    end

    settle_pipeline();
    $display("Sent %0d pixels (%0d transparent, %0d opaque, %0d blended) over %0d layouts",
             n_sent, n_clear, n_opaque, n_mixed, n_layouts);
    $display("Checked %0d results under mixed sender gaps and receiver stalls", checked);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/abpp_pkg.sv
rtl/abpp_cfg.sv
rtl/abpp_chan.sv
rtl/alpha_blend_pixel_packer_top.sv
dv/alpha_blend_pixel_packer_checker.sv
dv/alpha_blend_pixel_packer_top_test.sv
